// File: rtl/ssd_pkg.sv
// Shared constants for the segment-segment distance datapath.
`timescale 1ns / 1ps

package ssd_pkg;

    // fraction bits of the clamped segment parameters sc and tc
    localparam int PFRAC = 32;

    // limb width used to split wide multiplies into partial products
    localparam int MUL_LIMB = 24;

    // register stages through one split multiplier
    localparam int MUL_LAT = 3;

    // width of the parallel limit register
    localparam int LIMIT_W = 32;

endpackage

// File: rtl/ssd_if.sv
// Valid/ready channel interfaces for the segment pair word and the distance word.
`timescale 1ns / 1ps

interface ssd_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg1_head_x;
    logic signed [COORD_WIDTH-1:0] seg1_head_y;
    logic signed [COORD_WIDTH-1:0] seg1_head_z;
    logic signed [COORD_WIDTH-1:0] seg1_tail_x;
    logic signed [COORD_WIDTH-1:0] seg1_tail_y;
    logic signed [COORD_WIDTH-1:0] seg1_tail_z;
    logic signed [COORD_WIDTH-1:0] seg2_head_x;
    logic signed [COORD_WIDTH-1:0] seg2_head_y;
    logic signed [COORD_WIDTH-1:0] seg2_head_z;
    logic signed [COORD_WIDTH-1:0] seg2_tail_x;
    logic signed [COORD_WIDTH-1:0] seg2_tail_y;
    logic signed [COORD_WIDTH-1:0] seg2_tail_z;

    modport source (
        output valid, seg1_head_x, seg1_head_y, seg1_head_z,
        output seg1_tail_x, seg1_tail_y, seg1_tail_z,
        output seg2_head_x, seg2_head_y, seg2_head_z,
        output seg2_tail_x, seg2_tail_y, seg2_tail_z,
        input  ready
    );
    modport sink (
        input  valid, seg1_head_x, seg1_head_y, seg1_head_z,
        input  seg1_tail_x, seg1_tail_y, seg1_tail_z,
        input  seg2_head_x, seg2_head_y, seg2_head_z,
        input  seg2_tail_x, seg2_tail_y, seg2_tail_z,
        output ready
    );
endinterface

interface ssd_out_if #(
    parameter int DIST_WIDTH = 25
);
    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] seg_distance;

    modport source (output valid, seg_distance, input ready);
    modport sink (input valid, seg_distance, output ready);
endinterface

// File: rtl/segment_segment_distance_unit.sv
// Top level: streaming shortest distance between two 3D segments.
`timescale 1ns / 1ps

// Usage
//   in_ch   : one word per segment pair, twelve signed Q12.12 end point
//             coordinates; taken when valid and ready are both high.
//   out_ch  : one word per accepted pair, seg_distance in unsigned Q13.12,
//             the floor of the closest-approach length.
//   cfg_wr_*: parallel_limit, written on any edge with cfg_wr_en high; users must
//             write it only while no pair is in flight (unenforced). Reset value 1.
// Throughput: one pair per cycle unless the output stalls. Every stage
//   advances together, through the two 33-stage parameter dividers, the
//   one-stage-per-bit square root and the three-stage split multipliers
//   of the dot product, cross product, closest-point and squaring steps.
// Stall: when a finished word sits at the output and out_ch.ready is low,
//   the whole pipeline holds and in_ch.ready drops; nothing is lost or
//   repeated. Bubbles inside the pipeline hold their place during a stall.
// Reset (rst_n low, asynchronous): all valid bits clear, the pipeline is
//   empty, parallel_limit returns to 1.

module segment_segment_distance_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [ssd_pkg::LIMIT_W-1:0]  cfg_wr_data,
    ssd_in_if.sink                       in_ch,
    ssd_out_if.source                    out_ch
);

    localparam int DW   = COORD_WIDTH + 1;      // coordinate differences
    localparam int SQW  = 2 * DW + 2;           // dot products
    localparam int DDW  = 2 * SQW + 1;          // denominator and numerators
    localparam int PF   = ssd_pkg::PFRAC;
    localparam int SCW  = PF + 2;               // sc, tc as signed operands
    localparam int CMW  = DW + PF + 2;          // closest-approach component
    localparam int SUMW = 2 * CMW + 2;          // squared length
    localparam int SQIN = SUMW - 2 * PF;        // radicand after dropping 2*PF
    localparam int RW   = SQIN / 2;
    localparam int ML   = ssd_pkg::MUL_LAT;
    localparam int LW   = ssd_pkg::LIMIT_W;

    localparam int D_DOT = ML + 1;
    localparam int D_UV  = 2 * (ML + 1) + 2 + PF + 1;
    localparam int D_W   = D_UV + ML;
    localparam int LAT   = 1 + 2 * (ML + 1) + 2 + (PF + 1) + 2 * (ML + 1) + RW;

    // ------------------------------------------------------------------
    // flow control: single advance for every stage
    // ------------------------------------------------------------------
    logic           adv;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;
    logic [LW-1:0]  limit_reg;

    assign adv         = !valid_reg[LAT-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign valid_next  = {valid_reg[LAT-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            limit_reg <= LW'(1);
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= valid_next;
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: u = s1 tail - s1 head, v = s2 tail - s2 head, w = s1h - s2h
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] p1h [3];
    logic signed [COORD_WIDTH-1:0] p1t [3];
    logic signed [COORD_WIDTH-1:0] p2h [3];
    logic signed [COORD_WIDTH-1:0] p2t [3];
    logic signed [DW-1:0]          u_reg [3];
    logic signed [DW-1:0]          v_reg [3];
    logic signed [DW-1:0]          w_reg [3];

    assign p1h[0] = in_ch.seg1_head_x;
    assign p1h[1] = in_ch.seg1_head_y;
    assign p1h[2] = in_ch.seg1_head_z;
    assign p1t[0] = in_ch.seg1_tail_x;
    assign p1t[1] = in_ch.seg1_tail_y;
    assign p1t[2] = in_ch.seg1_tail_z;
    assign p2h[0] = in_ch.seg2_head_x;
    assign p2h[1] = in_ch.seg2_head_y;
    assign p2h[2] = in_ch.seg2_head_z;
    assign p2t[0] = in_ch.seg2_tail_x;
    assign p2t[1] = in_ch.seg2_tail_y;
    assign p2t[2] = in_ch.seg2_tail_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DW'(p1t[i]) - DW'(p1h[i]);
                v_reg[i] <= DW'(p2t[i]) - DW'(p2h[i]);
                w_reg[i] <= DW'(p1h[i]) - DW'(p2h[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   dop_a [5][3];
    logic signed [DW-1:0]   dop_b [5][3];
    logic signed [2*DW-1:0] dprod [5][3];
    logic signed [SQW-1:0]  dot_reg [5];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dop_a[0][i] = u_reg[i];  dop_b[0][i] = u_reg[i];
            dop_a[1][i] = u_reg[i];  dop_b[1][i] = v_reg[i];
            dop_a[2][i] = v_reg[i];  dop_b[2][i] = v_reg[i];
            dop_a[3][i] = u_reg[i];  dop_b[3][i] = w_reg[i];
            dop_a[4][i] = v_reg[i];  dop_b[4][i] = w_reg[i];
        end
    end

    for (genvar k = 0; k < 5; k++)
    begin : g_dot
        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            ssd_mul #(
                .AW (DW),
                .BW (DW)
            ) u_mul (
                .clk (clk),
                .en  (adv),
                .a   (dop_a[k][i]),
                .b   (dop_b[k][i]),
                .p   (dprod[k][i])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 5; k++)
            begin
                dot_reg[k] <= SQW'(dprod[k][0]) + SQW'(dprod[k][1]) + SQW'(dprod[k][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // D = ac - bb, sN = be - cd, tN = ae - bd
    // ------------------------------------------------------------------
    logic signed [SQW-1:0]   xop_a [6];
    logic signed [SQW-1:0]   xop_b [6];
    logic signed [2*SQW-1:0] xprod [6];
    logic signed [DDW-1:0]   den_reg;
    logic signed [DDW-1:0]   sn0_reg;
    logic signed [DDW-1:0]   tn0_reg;

    assign xop_a[0] = dot_reg[0];  assign xop_b[0] = dot_reg[2];   // a*c
    assign xop_a[1] = dot_reg[1];  assign xop_b[1] = dot_reg[1];   // b*b
    assign xop_a[2] = dot_reg[1];  assign xop_b[2] = dot_reg[4];   // b*e
    assign xop_a[3] = dot_reg[2];  assign xop_b[3] = dot_reg[3];   // c*d
    assign xop_a[4] = dot_reg[0];  assign xop_b[4] = dot_reg[4];   // a*e
    assign xop_a[5] = dot_reg[1];  assign xop_b[5] = dot_reg[3];   // b*d

    for (genvar k = 0; k < 6; k++)
    begin : g_cross
        ssd_mul #(
            .AW (SQW),
            .BW (SQW)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (xop_a[k]),
            .b   (xop_b[k]),
            .p   (xprod[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg <= DDW'(xprod[0]) - DDW'(xprod[1]);
            sn0_reg <= DDW'(xprod[2]) - DDW'(xprod[3]);
            tn0_reg <= DDW'(xprod[4]) - DDW'(xprod[5]);
        end
    end

    // dot products held back to line up with the cross products
    logic [5*SQW-1:0]      dot_pack;
    logic [5*SQW-1:0]      dot_late;
    logic signed [SQW-1:0] a_d;
    logic signed [SQW-1:0] b_d;
    logic signed [SQW-1:0] c_d;
    logic signed [SQW-1:0] d_d;
    logic signed [SQW-1:0] e_d;

    assign dot_pack = {dot_reg[4], dot_reg[3], dot_reg[2], dot_reg[1], dot_reg[0]};

    ssd_delay #(
        .W (5 * SQW),
        .N (D_DOT)
    ) u_dot_dly (
        .clk (clk),
        .en  (adv),
        .d   (dot_pack),
        .q   (dot_late)
    );

    assign a_d = dot_late[0*SQW +: SQW];
    assign b_d = dot_late[1*SQW +: SQW];
    assign c_d = dot_late[2*SQW +: SQW];
    assign d_d = dot_late[3*SQW +: SQW];
    assign e_d = dot_late[4*SQW +: SQW];

    // ------------------------------------------------------------------
    // clamp, first half: parallel test and sc edges
    // ------------------------------------------------------------------
    logic signed [DDW-1:0] ax;
    logic signed [DDW-1:0] bx;
    logic signed [DDW-1:0] cx;
    logic signed [DDW-1:0] dx;
    logic signed [DDW-1:0] ex;
    logic signed [DDW-1:0] limit_x;
    logic signed [DDW-1:0] sn1_next, sd1_next, tn1_next, td1_next;
    logic signed [DDW-1:0] sn1_reg, sd1_reg, tn1_reg, td1_reg;
    logic signed [DDW-1:0] nd1_reg, ndb1_reg, a1_reg;
    logic                  nd_gt_a_reg, ndb_gt_a_reg;

    assign ax      = DDW'(a_d);
    assign bx      = DDW'(b_d);
    assign cx      = DDW'(c_d);
    assign dx      = DDW'(d_d);
    assign ex      = DDW'(e_d);
    assign limit_x = $signed({{(DDW-LW){1'b0}}, limit_reg});

    always_comb
    begin
        sd1_next = den_reg;
        td1_next = den_reg;
        sn1_next = sn0_reg;
        tn1_next = tn0_reg;
        priority if (den_reg < limit_x)
        begin
            // nearly parallel: pin sc to the first segment's head
            sn1_next = '0;
            sd1_next = DDW'(1);
            tn1_next = ex;
            td1_next = cx;
        end
        else if (sn0_reg < 0)
        begin
            sn1_next = '0;
            tn1_next = ex;
            td1_next = cx;
        end
        else if (sn0_reg > den_reg)
        begin
            sn1_next = den_reg;
            tn1_next = ex + bx;
            td1_next = cx;
        end
        else
        begin
            sn1_next = sn0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn1_reg      <= sn1_next;
            sd1_reg      <= sd1_next;
            tn1_reg      <= tn1_next;
            td1_reg      <= td1_next;
            nd1_reg      <= -dx;
            ndb1_reg     <= bx - dx;
            a1_reg       <= ax;
            nd_gt_a_reg  <= (-dx > ax);
            ndb_gt_a_reg <= ((bx - dx) > ax);
        end
    end

    // ------------------------------------------------------------------
    // clamp, second half: tc edges and the sc re-clamp
    // ------------------------------------------------------------------
    logic signed [DDW-1:0] sn2_next, sd2_next, tn2_next;
    logic signed [DDW-1:0] sn2_reg, sd2_reg, tn2_reg, td2_reg;

    always_comb
    begin
        sn2_next = sn1_reg;
        sd2_next = sd1_reg;
        tn2_next = tn1_reg;
        priority if (tn1_reg < 0)
        begin
            tn2_next = '0;
            priority if (nd1_reg < 0)
            begin
                sn2_next = '0;
            end
            else if (nd_gt_a_reg)
            begin
                sn2_next = sd1_reg;
            end
            else
            begin
                sn2_next = nd1_reg;
                sd2_next = a1_reg;
            end
        end
        else if (tn1_reg > td1_reg)
        begin
            tn2_next = td1_reg;
            priority if (ndb1_reg < 0)
            begin
                sn2_next = '0;
            end
            else if (ndb_gt_a_reg)
            begin
                sn2_next = sd1_reg;
            end
            else
            begin
                sn2_next = ndb1_reg;
                sd2_next = a1_reg;
            end
        end
        else
        begin
            tn2_next = tn1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn2_reg <= sn2_next;
            sd2_reg <= sd2_next;
            tn2_reg <= tn2_next;
            td2_reg <= td1_reg;
        end
    end

    // ------------------------------------------------------------------
    // sc = sN / sD, tc = tN / tD with PF fraction bits
    // ------------------------------------------------------------------
    logic [PF:0] sc;
    logic [PF:0] tc;

    ssd_div #(
        .NW (DDW)
    ) u_div_s (
        .clk  (clk),
        .en   (adv),
        .num  (sn2_reg),
        .den  (sd2_reg),
        .quot (sc)
    );

    ssd_div #(
        .NW (DDW)
    ) u_div_t (
        .clk  (clk),
        .en   (adv),
        .num  (tn2_reg),
        .den  (td2_reg),
        .quot (tc)
    );

    // ------------------------------------------------------------------
    // closest-approach vector: w*2^PF + sc*u - tc*v
    // ------------------------------------------------------------------
    logic [6*DW-1:0]       uv_pack;
    logic [6*DW-1:0]       uv_late;
    logic [3*DW-1:0]       w_pack;
    logic [3*DW-1:0]       w_late;
    logic signed [DW-1:0]  u_d [3];
    logic signed [DW-1:0]  v_d [3];
    logic signed [DW-1:0]  w_d [3];
    logic signed [SCW-1:0] sc_s;
    logic signed [SCW-1:0] tc_s;
    logic signed [CMW-1:0] su_prod [3];
    logic signed [CMW-1:0] tv_prod [3];
    logic signed [CMW-1:0] comp_reg [3];

    assign uv_pack = {v_reg[2], v_reg[1], v_reg[0], u_reg[2], u_reg[1], u_reg[0]};
    assign w_pack  = {w_reg[2], w_reg[1], w_reg[0]};

    ssd_delay #(
        .W (6 * DW),
        .N (D_UV)
    ) u_uv_dly (
        .clk (clk),
        .en  (adv),
        .d   (uv_pack),
        .q   (uv_late)
    );

    ssd_delay #(
        .W (3 * DW),
        .N (D_W)
    ) u_w_dly (
        .clk (clk),
        .en  (adv),
        .d   (w_pack),
        .q   (w_late)
    );

    assign sc_s = $signed({1'b0, sc});
    assign tc_s = $signed({1'b0, tc});

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        assign u_d[i] = uv_late[i*DW +: DW];
        assign v_d[i] = uv_late[(i+3)*DW +: DW];
        assign w_d[i] = w_late[i*DW +: DW];

        ssd_mul #(
            .AW (SCW),
            .BW (DW)
        ) u_mul_s (
            .clk (clk),
            .en  (adv),
            .a   (sc_s),
            .b   (u_d[i]),
            .p   (su_prod[i])
        );

        ssd_mul #(
            .AW (SCW),
            .BW (DW)
        ) u_mul_t (
            .clk (clk),
            .en  (adv),
            .a   (tc_s),
            .b   (v_d[i]),
            .p   (tv_prod[i])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                comp_reg[i] <= (CMW'(w_d[i]) <<< PF) + su_prod[i] - tv_prod[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // squared length
    // ------------------------------------------------------------------
    logic signed [2*CMW-1:0] sq_prod [3];
    logic signed [SUMW-1:0]  sum_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_square
        ssd_mul #(
            .AW (CMW),
            .BW (CMW)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (comp_reg[i]),
            .b   (comp_reg[i]),
            .p   (sq_prod[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= SUMW'(sq_prod[0]) + SUMW'(sq_prod[1]) + SUMW'(sq_prod[2]);
        end
    end

    // ------------------------------------------------------------------
    // floor(sqrt(sum) / 2^PF) == floor(sqrt(floor(sum / 4^PF)))
    // ------------------------------------------------------------------
    logic [RW-1:0] root;

    ssd_sqrt #(
        .XW (SQIN)
    ) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (sum_reg[SUMW-1:2*PF]),
        .root (root)
    );

    assign out_ch.valid        = valid_reg[LAT-1];
    assign out_ch.seg_distance = root[DW-1:0];

endmodule

// File: rtl/ssd_delay.sv
// Enabled shift line that keeps side data aligned with the datapath.
`timescale 1ns / 1ps

module ssd_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

// File: rtl/ssd_mul.sv
// Signed multiplier split into limb partial products over three stages.
`timescale 1ns / 1ps

module ssd_mul #(
    parameter int AW = 25,
    parameter int BW = 25
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int L   = ssd_pkg::MUL_LIMB;
    localparam int KA  = (AW + L - 1) / L;
    localparam int KB  = (BW + L - 1) / L;
    localparam int EAW = KA * L;
    localparam int EBW = KB * L;
    localparam int PPW = 2 * L + 2;
    localparam int SW  = EAW + EBW;

    logic signed [EAW-1:0] ax;
    logic signed [EBW-1:0] bx;
    logic signed [L:0]     al [KA];
    logic signed [L:0]     bl [KB];

    logic signed [PPW-1:0] pp_reg [KA][KB];
    logic signed [SW-1:0]  row_next [KA];
    logic signed [SW-1:0]  row_reg [KA];
    logic signed [SW-1:0]  sum_next;
    logic signed [SW-1:0]  sum_reg;

    assign ax = EAW'(a);
    assign bx = EBW'(b);

    // lower limbs are unsigned, the top limb carries the sign
    for (genvar i = 0; i < KA; i++)
    begin : g_al
        if (i == KA - 1)
        begin : g_top
            assign al[i] = $signed({ax[EAW-1], ax[i*L +: L]});
        end
        else
        begin : g_low
            assign al[i] = $signed({1'b0, ax[i*L +: L]});
        end
    end

    for (genvar j = 0; j < KB; j++)
    begin : g_bl
        if (j == KB - 1)
        begin : g_top
            assign bl[j] = $signed({bx[EBW-1], bx[j*L +: L]});
        end
        else
        begin : g_low
            assign bl[j] = $signed({1'b0, bx[j*L +: L]});
        end
    end

    always_comb
    begin
        for (int i = 0; i < KA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < KB; j++)
            begin
                row_next[i] = row_next[i] + (SW'(pp_reg[i][j]) <<< (j * L));
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < KA; i++)
        begin
            sum_next = sum_next + (row_reg[i] <<< (i * L));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < KA; i++)
            begin
                for (int j = 0; j < KB; j++)
                begin
                    pp_reg[i][j] <= al[i] * bl[j];
                end
                row_reg[i] <= row_next[i];
            end
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg[AW+BW-1:0];

endmodule

// File: rtl/ssd_div.sv
// Pipelined restoring divider: floor(num * 2^PFRAC / den), clamped to [0, 1].
`timescale 1ns / 1ps

module ssd_div #(
    parameter int NW = 105
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [NW-1:0]       num,
    input  logic signed [NW-1:0]       den,
    output logic [ssd_pkg::PFRAC:0]    quot
);

    localparam int PF = ssd_pkg::PFRAC;

    logic [NW-1:0] r_reg    [PF+1];
    logic [NW-1:0] d_reg    [PF+1];
    logic [PF-1:0] q_reg    [PF+1];
    logic          zero_reg [PF+1];
    logic          sat_reg  [PF+1];

    // entry stage: sort out the trivial cases
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (den <= 0) || (num <= 0);
            sat_reg[0]  <= (num >= den);
            r_reg[0]    <= num;
            d_reg[0]    <= den;
            q_reg[0]    <= '0;
        end
    end

    // one quotient bit per stage; remainder stays below den
    for (genvar k = 1; k <= PF; k++)
    begin : g_step
        logic [NW-1:0] r2;
        logic          ge;

        assign r2 = {r_reg[k-1][NW-2:0], 1'b0};
        assign ge = (r2 >= d_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= ge ? (r2 - d_reg[k-1]) : r2;
                d_reg[k]    <= d_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][PF-2:0], ge};
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    always_comb
    begin
        priority if (zero_reg[PF])
        begin
            quot = '0;
        end
        else if (sat_reg[PF])
        begin
            quot = {1'b1, {PF{1'b0}}};
        end
        else
        begin
            quot = {1'b0, q_reg[PF]};
        end
    end

endmodule

// File: rtl/ssd_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
`timescale 1ns / 1ps

module ssd_sqrt #(
    parameter int XW = 56
) (
    input  logic              clk,
    input  logic              en,
    input  logic [XW-1:0]     x,
    output logic [XW/2-1:0]   root
);

    localparam int RW  = XW / 2;
    localparam int RMW = RW + 3;

    logic [XW-1:0]  x_reg    [RW];
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic [XW-1:0]  xi;
        logic [RMW-1:0] remi;
        logic [RW-1:0]  rooti;
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign xi    = x;
            assign remi  = '0;
            assign rooti = '0;
        end
        else
        begin : g_next
            assign xi    = x_reg[k-1];
            assign remi  = rem_reg[k-1];
            assign rooti = root_reg[k-1];
        end

        assign rem2  = {remi[RMW-3:0], xi[XW-1:XW-2]};
        assign trial = RMW'({rooti, 2'b01});
        assign ge    = (rem2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {xi[XW-3:0], 2'b00};
                rem_reg[k]  <= ge ? (rem2 - trial) : rem2;
                root_reg[k] <= {rooti[RW-2:0], ge};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: rtl/ssd_checker.sv
// Port-level checks for the segment-segment distance unit, with its bind.
`timescale 1ns / 1ps

module ssd_checker #(
    parameter int DIST_WIDTH = 25
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DIST_WIDTH-1:0] out_data
);

    // during reset the pipeline is empty and shows no word
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word valid during reset");

    // input is held off only while a finished word is refused downstream
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // a refused word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // and keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output word changed while stalled");

endmodule

bind segment_segment_distance_unit ssd_checker #(
    .DIST_WIDTH (COORD_WIDTH + 1)
) u_ssd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.seg_distance)
);

// File: verif/ssd_checker.sv
// Checker: predicts the distance for every accepted segment pair and compares outputs.
`timescale 1ns / 1ps

module ssd_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    ssd_in_if           in_ch,
    ssd_out_if          out_ch,
    output int          fail_count,
    output int          pending
);
    typedef logic signed [255:0] wide_t;
    typedef logic signed [23:0] pair_t [12];

    logic [31:0] limit_copy;
    logic [24:0] dist_queue [$];

    // clamped parameter, 32 fraction bits, in [0, 1]
    function automatic wide_t clamp_ratio(wide_t num, wide_t den);
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return wide_t'(1) <<< 32;
        return (num <<< 32) / den;
    endfunction

    function automatic logic [24:0] closest_distance(pair_t p, logic [31:0] lim);
        wide_t u [3];
        wide_t v [3];
        wide_t w [3];
        wide_t a, b, c, d, e, den, limw, sn, sd, tn, td, nd, ndb;
        wide_t sc, tc, comp, sum, root, cand;
        int i, k;
        for (i = 0; i < 3; i++)
        begin
            u[i] = wide_t'(p[3+i]) - wide_t'(p[i]);
            v[i] = wide_t'(p[9+i]) - wide_t'(p[6+i]);
            w[i] = wide_t'(p[i]) - wide_t'(p[6+i]);
        end
        a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
        den = a*c - b*b;
        sd = den;
        td = den;
        limw = 0;
        limw[31:0] = lim;
        if (den < limw)
        begin
            // near parallel: pin sc at 0
            sn = 0; sd = 1; tn = e; td = c;
        end
        else
        begin
            sn = b*e - c*d;
            tn = a*e - b*d;
            if (sn < 0)
            begin
                sn = 0; tn = e; td = c;
            end
            else if (sn > sd)
            begin
                sn = sd; tn = e + b; td = c;
            end
        end
        nd = -d;
        ndb = nd + b;
        if (tn < 0)
        begin
            tn = 0;
            if (nd < 0) sn = 0;
            else if (nd > a) sn = sd;
            else begin sn = nd; sd = a; end
        end
        else if (tn > td)
        begin
            tn = td;
            if (ndb < 0) sn = 0;
            else if (ndb > a) sn = sd;
            else begin sn = ndb; sd = a; end
        end
        sc = clamp_ratio(sn, sd);
        tc = clamp_ratio(tn, td);
        sum = 0;
        for (i = 0; i < 3; i++)
        begin
            comp = (w[i] <<< 32) + sc*u[i] - tc*v[i];
            sum = sum + comp*comp;
        end
        root = 0;
        for (k = 63; k >= 0; k--)
        begin
            cand = root | (wide_t'(1) <<< k);
            if (cand*cand <= sum)
                root = cand;
        end
        return root[56:32];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pair_t p;
        logic [24:0] want;
        if (!rst_n)
        begin
            limit_copy = 32'd1;
            dist_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (dist_queue.size() == 0)
                begin
                    $error("unexpected distance word %0d", out_ch.seg_distance);
                    fail_count++;
                end
                else
                begin
                    want = dist_queue.pop_front();
                    if (out_ch.seg_distance !== want)
                    begin
                        $error("seg_distance: expected %0d, got %0d", want,
                               out_ch.seg_distance);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                p = '{in_ch.seg1_head_x, in_ch.seg1_head_y, in_ch.seg1_head_z,
                      in_ch.seg1_tail_x, in_ch.seg1_tail_y, in_ch.seg1_tail_z,
                      in_ch.seg2_head_x, in_ch.seg2_head_y, in_ch.seg2_head_z,
                      in_ch.seg2_tail_x, in_ch.seg2_tail_y, in_ch.seg2_tail_z};
                dist_queue = {dist_queue, closest_distance(p, limit_copy)};
            end
            if (cfg_wr_en)
                limit_copy = cfg_wr_data;
            pending = dist_queue.size();
        end
    end
endmodule

// File: verif/tb_segment_segment_distance_unit.sv
// Testbench top: stimulus, flow control and verdict for the segment distance unit.
`timescale 1ns / 1ps

module tb_segment_segment_distance_unit;
    typedef logic signed [23:0] pair_t [12];

    localparam int LATENCY   = 80;
    localparam int HOLD_LEN  = 400;   // long receiver stall, cycles
    localparam int STALL_MAX = 5000;  // watchdog: busy cycles with no word moving
    localparam int CHUNK     = 258;   // random words per configuration setting

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          fail_count;
    int          pending;

    // idle rates in percent, changed by the stimulus process only
    int snd_idle;
    int rcv_idle;
    // toggled to request a long receiver stall
    bit hold_go;
    bit hold_seen;
    int hold_left;
    int quiet;

    ssd_in_if  #(.COORD_WIDTH(24)) in_ch ();
    ssd_out_if #(.DIST_WIDTH(25))  out_ch ();

    segment_segment_distance_unit #(.COORD_WIDTH(24)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    ssd_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Watchdog: only counts while something is in flight or offered.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else if (pending > 0 || in_ch.valid)
            quiet <= quiet + 1;
        if (quiet >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Coordinate draw: full range, near origin, or mid range.
    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(128)) - 64);
            default: return 24'(int'($urandom_range(65535)) - 32768);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int kind, mode, i, sgn;
        kind = $urandom_range(9);
        mode = $urandom_range(2);
        for (i = 0; i < 12; i++)
            p[i] = rand_coord((kind == 7) ? $urandom_range(2) : mode);
        case (kind)
            4:
            begin
                // parallel or anti-parallel second segment
                sgn = $urandom_range(1);
                for (i = 0; i < 3; i++)
                    p[9+i] = sgn ? p[6+i] + (p[3+i] - p[i]) : p[6+i] - (p[3+i] - p[i]);
            end
            5:
            begin
                // one segment collapsed to a point
                if ($urandom_range(1))
                    for (i = 0; i < 3; i++) p[3+i] = p[i];
                else
                    for (i = 0; i < 3; i++) p[9+i] = p[6+i];
            end
            6:
            begin
                // second segment takes each coordinate from the first's head or tail at random
                for (i = 0; i < 6; i++) p[6+i] = p[$urandom_range(1) ? i : (i + 3) % 6];
            end
            default: ;
        endcase
        return p;
    endfunction

    // Offer one word and hold it until the unit takes it.
    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.seg1_head_x <= p[0];  in_ch.seg1_head_y <= p[1];  in_ch.seg1_head_z <= p[2];
        in_ch.seg1_tail_x <= p[3];  in_ch.seg1_tail_y <= p[4];  in_ch.seg1_tail_z <= p[5];
        in_ch.seg2_head_x <= p[6];  in_ch.seg2_head_y <= p[7];  in_ch.seg2_head_z <= p[8];
        in_ch.seg2_tail_x <= p[9];  in_ch.seg2_tail_y <= p[10]; in_ch.seg2_tail_z <= p[11];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drain, let the pipeline settle, then write the limit register.
    task automatic set_limit(logic [31:0] value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        pair_t p;
        logic [31:0] limits [6];
        int i, j, n;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.seg1_head_x = '0; in_ch.seg1_head_y = '0; in_ch.seg1_head_z = '0;
        in_ch.seg1_tail_x = '0; in_ch.seg1_tail_y = '0; in_ch.seg1_tail_z = '0;
        in_ch.seg2_head_x = '0; in_ch.seg2_head_y = '0; in_ch.seg2_head_z = '0;
        in_ch.seg2_tail_x = '0; in_ch.seg2_tail_y = '0; in_ch.seg2_tail_z = '0;
        out_ch.ready = 1'b0;
        snd_idle = 7;
        rcv_idle = 50;
        hold_go = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset limit of 1.
        for (n = 0; n < 12; n++)
        begin
            for (i = 0; i < 12; i++) p[i] = '0;
            case (n)
                0: ;                                       // everything at the origin
                1: for (i = 0; i < 12; i++) p[i] = 24'sh7FFFFF;
                2: for (i = 0; i < 12; i++) p[i] = 24'sh800000;
                3: for (i = 0; i < 12; i++) p[i] = (i < 6) ? 24'sh7FFFFF : 24'sh800000;
                4: for (i = 0; i < 12; i++) p[i] = (i % 6 < 3) ? 24'sh800000 : 24'sh7FFFFF;
                5:
                begin
                    // crossing segments, interior closest points
                    p[0] = -24'sd4096; p[3] = 24'sd4096; p[7] = -24'sd4096;
                    p[10] = 24'sd4096; p[8] = 24'sd8192; p[11] = 24'sd8192;
                end
                6:
                begin
                    // exactly parallel, offset
                    p[3] = 24'sd4096; p[7] = 24'sd4096; p[9] = 24'sd4096; p[10] = 24'sd4096;
                end
                7:
                begin
                    // both point-like
                    p[0] = 24'sd100; p[3] = 24'sd100; p[6] = -24'sd7; p[9] = -24'sd7;
                end
                8:
                begin
                    // collinear, disjoint: clamps on both ends
                    p[3] = 24'sd10; p[6] = 24'sd50; p[9] = 24'sd90;
                end
                9:
                begin
                    // collinear, reversed and overlapping
                    p[3] = 24'sd80; p[6] = 24'sd60; p[9] = 24'sd20;
                end
                10:
                begin
                    // tail past the end of the second segment
                    p[0] = 24'sd5000; p[3] = 24'sd9000; p[1] = 24'sd1;
                    p[9] = 24'sd100; p[11] = 24'sd100;
                end
                default:
                    for (i = 0; i < 12; i++) p[i] = 24'($urandom);
            endcase
            send_pair(p);
        end

        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = $urandom;
        limits[3] = $urandom_range(1000);
        limits[4] = 32'd1;
        limits[5] = $urandom;

        for (j = 0; j < 6; j++)
        begin
            set_limit(limits[j]);
            // idle profile: sender light/receiver heavy, then swapped, then none
            snd_idle = (j < 2) ? 7 : (j < 4) ? 50 : 0;
            rcv_idle = (j < 2) ? 50 : (j < 4) ? 7 : 0;
            if (j == 0 || j == 4)
                hold_go = ~hold_go;
            for (n = 0; n < CHUNK; n++)
                send_pair(rand_pair());
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
